### hw/rtl/ctsd_pkg.sv
// Shared types, codes and the seven-segment decoder of the clock display controller.
`default_nettype none

package ctsd_pkg;

    // Request kinds carried on the input channel.
    typedef enum logic [1:0] {
        KIND_SET  = 2'd0,
        KIND_MODE = 2'd1,
        KIND_RTC  = 2'd2,
        KIND_SCAN = 2'd3
    } kind_t;

    // Time-setting steps: one per edit digit, then idle.
    typedef enum logic [2:0] {
        STEP_HT   = 3'd0,
        STEP_HO   = 3'd1,
        STEP_MT   = 3'd2,
        STEP_MO   = 3'd3,
        STEP_IDLE = 3'd4
    } step_t;

    // One result request as it leaves the controller.
    typedef struct packed {
        logic [6:0] seg_pattern;
        logic [1:0] digit_index;
        logic       colon_on;
        logic       commit;
        logic [5:0] set_hours_bcd;
        logic [6:0] set_minutes_bcd;
    } res_t;

    // Segments a to g, bit 0 is a; anything above nine is blank.
    function automatic logic [6:0] seg_of(input logic [3:0] digit);
        logic [6:0] pattern;
        case (digit)
            4'd0:    pattern = 7'h3F;
            4'd1:    pattern = 7'h06;
            4'd2:    pattern = 7'h5B;
            4'd3:    pattern = 7'h4F;
            4'd4:    pattern = 7'h66;
            4'd5:    pattern = 7'h6D;
            4'd6:    pattern = 7'h7D;
            4'd7:    pattern = 7'h07;
            4'd8:    pattern = 7'h7F;
            4'd9:    pattern = 7'h6F;
            default: pattern = 7'h00;
        endcase
        return pattern;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ctsd_if.sv
// Valid/ready channel interfaces for the input and result requests.
`default_nettype none

interface ctsd_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] hours_raw;
    logic [7:0] minutes_raw;
    logic [7:0] seconds_raw;

    modport source (output valid, kind, hours_raw, minutes_raw, seconds_raw, input ready);
    modport sink   (input valid, kind, hours_raw, minutes_raw, seconds_raw, output ready);
endinterface

interface ctsd_rsp_if;
    logic       valid;
    logic       ready;
    logic [6:0] seg_pattern;
    logic [1:0] digit_index;
    logic       colon_on;
    logic       commit;
    logic [5:0] set_hours_bcd;
    logic [6:0] set_minutes_bcd;

    modport source (output valid, seg_pattern, digit_index, colon_on, commit,
                    set_hours_bcd, set_minutes_bcd, input ready);
    modport sink   (input valid, seg_pattern, digit_index, colon_on, commit,
                    set_hours_bcd, set_minutes_bcd, output ready);
endinterface

`default_nettype wire

### hw/rtl/ctsd_core.sv
// Time-setting state machine, RTC digit store and display scan of the clock controller.
`default_nettype none

module ctsd_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          acc,
    input  wire logic [1:0]    kind,
    input  wire logic [7:0]    hours_raw,
    input  wire logic [7:0]    minutes_raw,
    input  wire logic [7:0]    seconds_raw,
    output logic               res_valid,
    output ctsd_pkg::res_t     res
);
    import ctsd_pkg::*;

    kind_t      kind_c;
    logic       editing;

    step_t      step_reg, step_next;
    logic [1:0] ht_reg, ht_next;
    logic [3:0] ho_reg, ho_next;
    logic [2:0] mt_reg, mt_next;
    logic [3:0] mo_reg, mo_next;
    logic [1:0] sh_ht_reg, sh_ht_next;
    logic [3:0] sh_ho_reg, sh_ho_next;
    logic [2:0] sh_mt_reg, sh_mt_next;
    logic [3:0] sh_mo_reg, sh_mo_next;
    logic       odd_reg, odd_next;
    logic [1:0] scan_reg, scan_next;
    logic [3:0] disp_digit;

    assign kind_c  = kind_t'(kind);
    assign editing = (step_reg != STEP_IDLE);

    // Mode button walks idle, then the four edit digits, then back to idle.
    always_comb
    begin
        step_next = step_reg;
        if (acc && kind_c == KIND_MODE)
        begin
            unique case (step_reg)
                STEP_IDLE: step_next = STEP_HT;
                STEP_HT:   step_next = STEP_HO;
                STEP_HO:   step_next = STEP_MT;
                STEP_MT:   step_next = STEP_MO;
                STEP_MO:   step_next = STEP_IDLE;
                default:   step_next = STEP_IDLE;
            endcase
        end
    end

    // Set button bumps the selected edit digit within its wrap limit.
    always_comb
    begin
        ht_next = ht_reg;
        ho_next = ho_reg;
        mt_next = mt_reg;
        mo_next = mo_reg;
        if (acc && kind_c == KIND_SET)
        begin
            unique case (step_reg)
                STEP_HT: ht_next = (ht_reg < 2'd2) ? ht_reg + 2'd1 : 2'd0;
                STEP_HO:
                begin
                    if (ht_reg != 2'd2 && ho_reg < 4'd9)
                        ho_next = ho_reg + 4'd1;
                    else if (ht_reg == 2'd2 && ho_reg < 4'd3)
                        ho_next = ho_reg + 4'd1;
                    else
                        ho_next = 4'd0;
                end
                STEP_MT: mt_next = (mt_reg < 3'd5) ? mt_reg + 3'd1 : 3'd0;
                STEP_MO: mo_next = (mo_reg < 4'd9) ? mo_reg + 4'd1 : 4'd0;
                default: ;
            endcase
        end
    end

    // RTC samples refresh the shown digits only while not editing.
    always_comb
    begin
        sh_ht_next = sh_ht_reg;
        sh_ho_next = sh_ho_reg;
        sh_mt_next = sh_mt_reg;
        sh_mo_next = sh_mo_reg;
        odd_next   = odd_reg;
        if (acc && kind_c == KIND_RTC && !editing)
        begin
            sh_ht_next = hours_raw[5:4];
            sh_ho_next = hours_raw[3:0];
            sh_mt_next = minutes_raw[6:4];
            sh_mo_next = minutes_raw[3:0];
            odd_next   = seconds_raw[0];
        end
    end

    // Each scan tick moves on to the next display position.
    always_comb
    begin
        scan_next = scan_reg;
        if (acc && kind_c == KIND_SCAN)
            scan_next = scan_reg + 2'd1;
    end

    // Digit at the current scan position, from the edit or the RTC set.
    always_comb
    begin
        unique case (scan_reg)
            2'd0:    disp_digit = editing ? {2'b00, ht_reg} : {2'b00, sh_ht_reg};
            2'd1:    disp_digit = editing ? ho_reg : sh_ho_reg;
            2'd2:    disp_digit = editing ? {1'b0, mt_reg} : {1'b0, sh_mt_reg};
            default: disp_digit = editing ? mo_reg : sh_mo_reg;
        endcase
    end

    // Result request: a scan tick, or the time write on the last mode press.
    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        if (acc)
        begin
            case (kind_c)
                KIND_MODE:
                begin
                    if (step_reg == STEP_MO)
                    begin
                        res_valid           = 1'b1;
                        res.commit          = 1'b1;
                        res.set_hours_bcd   = {ht_reg, ho_reg};
                        res.set_minutes_bcd = {mt_reg, mo_reg};
                    end
                end
                KIND_SCAN:
                begin
                    res_valid       = 1'b1;
                    res.seg_pattern = seg_of(disp_digit);
                    res.digit_index = scan_reg;
                    res.colon_on    = editing ? 1'b1 : odd_reg;
                end
                default: ;
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_IDLE;
            ht_reg    <= '0;
            ho_reg    <= '0;
            mt_reg    <= '0;
            mo_reg    <= '0;
            sh_ht_reg <= '0;
            sh_ho_reg <= '0;
            sh_mt_reg <= '0;
            sh_mo_reg <= '0;
            odd_reg   <= 1'b0;
            scan_reg  <= '0;
        end
        else
        begin
            step_reg  <= step_next;
            ht_reg    <= ht_next;
            ho_reg    <= ho_next;
            mt_reg    <= mt_next;
            mo_reg    <= mo_next;
            sh_ht_reg <= sh_ht_next;
            sh_ho_reg <= sh_ho_next;
            sh_mt_reg <= sh_mt_next;
            sh_mo_reg <= sh_mo_next;
            odd_reg   <= odd_next;
            scan_reg  <= scan_next;
        end
    end

    // A time write only leaves on the press that ends the last edit digit.
    a_commit_step: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.commit |-> step_reg == STEP_MO && kind_c == KIND_MODE)
        else $error("time write outside the last edit step");

    // After the time write the controller is back in idle.
    a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        acc && kind_c == KIND_MODE && step_reg == STEP_MO |=> step_reg == STEP_IDLE)
        else $error("controller not idle after time write");

    // The hour tens edit digit never leaves 0 to 2.
    a_ht_range: assert property (@(posedge clk) disable iff (!rst_n)
        ht_reg <= 2'd2)
        else $error("hour tens edit digit out of range");

    // Scan position advances by exactly one per scan tick.
    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        acc && kind_c == KIND_SCAN |=> scan_reg == 2'($past(scan_reg) + 2'd1))
        else $error("scan position did not advance");

endmodule

`default_nettype wire

### hw/rtl/ctsd_out_buf.sv
// Two-entry result buffer: output register plus skid stage.
`default_nettype none

module ctsd_out_buf (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            res_valid,
    input  wire ctsd_pkg::res_t  res,
    output logic                 space,
    ctsd_rsp_if.source           rsp
);
    import ctsd_pkg::*;

    res_t out_reg, skid_reg;
    logic out_valid_reg, skid_valid_reg;
    logic take;

    // New requests are taken whenever the skid stage is free.
    assign space = !skid_valid_reg;
    assign take  = out_valid_reg && rsp.ready;

    // Control of the two entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || res_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload of the two entries.
    always_ff @(posedge clk)
    begin
        if (take || !out_valid_reg)
            out_reg <= skid_valid_reg ? skid_reg : res;
        else if (res_valid)
            skid_reg <= res;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.seg_pattern     = out_reg.seg_pattern;
    assign rsp.digit_index     = out_reg.digit_index;
    assign rsp.colon_on        = out_reg.colon_on;
    assign rsp.commit          = out_reg.commit;
    assign rsp.set_hours_bcd   = out_reg.set_hours_bcd;
    assign rsp.set_minutes_bcd = out_reg.set_minutes_bcd;

    // The skid stage is only ever filled behind a full output register.
    a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a request with the output register empty");

    // A drained output register is refilled from the skid stage.
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && take |=> out_valid_reg && !skid_valid_reg)
        else $error("skid stage not moved into the output register");

    // A result arriving behind a stalled output is parked, not lost.
    a_skid_park: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !take && res_valid |=> skid_valid_reg)
        else $error("result dropped behind a stalled output");

endmodule

`default_nettype wire

### hw/rtl/clock_time_set_and_display_scan_top.sv
// Top level of the four-digit clock display controller with button time setting.
//
// The block takes one request per clock cycle: set button, mode button, RTC sample or
// display scan tick. A scan tick gives one result with the segment pattern, position and
// colon of the current digit. The fifth mode press of a setting pass gives one time-write
// result: the first press leaves idle and the next three step through the edit digits.
// Other requests give none. Each request is decoded by a single stage of logic from the
// state registers. Its result appears in the output register on the next cycle, unless an
// earlier result is still waiting there. A two-entry output buffer lets requests keep
// flowing while a result waits, and ready drops only when both entries are held.
`default_nettype none

module clock_time_set_and_display_scan_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ctsd_req_if.sink   req,
    ctsd_rsp_if.source rsp
);
    import ctsd_pkg::*;

    logic acc;
    logic space;
    logic res_valid;
    res_t res;

    assign req.ready = space;
    assign acc       = req.valid && space;

    ctsd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .acc         (acc),
        .kind        (req.kind),
        .hours_raw   (req.hours_raw),
        .minutes_raw (req.minutes_raw),
        .seconds_raw (req.seconds_raw),
        .res_valid   (res_valid),
        .res         (res)
    );

    ctsd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .space     (space),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
